/* sv/sdta_pkg.sv */
// ----------------------------------------------------------------------------
// sdta_pkg
// Shared types and constants for the slow-data text assembler.
// ----------------------------------------------------------------------------
`default_nettype none

package sdta_pkg;

  localparam int unsigned TEXT_LEN   = 20;
  localparam int unsigned BLK_CHARS  = 5;
  localparam int unsigned CHAR_W     = 7;
  localparam int unsigned ADDR_W     = 5;
  localparam int unsigned KEY_W      = 24;

  localparam logic [KEY_W-1:0]    KEY_RESET = 24'h704F93;
  localparam logic [TEXT_LEN-1:0] FULL_MASK = 20'hFFFFF;
  localparam logic [3:0]          TEXT_TYPE = 4'h4;
  localparam logic [ADDR_W-1:0]   LAST_IDX  = 5'd19;
  localparam logic [ADDR_W-1:0]   END_CNT   = 5'd20;
  localparam logic [2:0]          LAST_WR   = 3'd4;

  typedef struct packed {
    logic [7:0] byte0_in;
    logic [7:0] byte1_in;
    logic [7:0] byte2_in;
    logic       is_sync;
    logic       clear_all;
  } in_word_t;

  typedef struct packed {
    logic [CHAR_W-1:0] text_char;
    logic [ADDR_W-1:0] char_index;
    logic              last_char;
  } out_word_t;

  typedef struct packed {
    logic              en;
    logic [ADDR_W-1:0] addr;
    logic [CHAR_W-1:0] data;
  } mem_wr_t;

  typedef struct packed {
    logic              en;
    logic [ADDR_W-1:0] addr;
  } mem_rd_t;

  typedef struct packed {
    logic              load;
    logic [ADDR_W-1:0] index;
    logic              last;
  } emit_t;

  typedef enum logic [2:0] {
    ST_IDLE  = 3'b001,
    ST_WRITE = 3'b010,
    ST_EMIT  = 3'b100
  } state_t;

endpackage

`default_nettype wire

/* sv/sdta_store.sv */
// ----------------------------------------------------------------------------
// sdta_store
// Twenty-entry character memory, one write and one registered read port.
// ----------------------------------------------------------------------------
`default_nettype none

module sdta_store (
  input  wire logic                               clk,
  input  wire sdta_pkg::mem_wr_t                  wr,
  input  wire sdta_pkg::mem_rd_t                  rd,
  output logic [sdta_pkg::CHAR_W-1:0]             rd_data
);
  import sdta_pkg::*;

  logic [CHAR_W-1:0] mem [TEXT_LEN];
  logic [CHAR_W-1:0] rd_data_r;

  always_ff @(posedge clk) begin
    if (wr.en) begin
      mem[wr.addr] <= wr.data;
    end
  end

  always_ff @(posedge clk) begin
    if (rd.en) begin
      rd_data_r <= mem[rd.addr];
    end
  end

  assign rd_data = rd_data_r;

endmodule

`default_nettype wire

/* sv/sdta_ctrl.sv */
// ----------------------------------------------------------------------------
// sdta_ctrl
// Descrambling, frame pairing, fill tracking and memory sequencing.
// ----------------------------------------------------------------------------
`default_nettype none

module sdta_ctrl (
  input  wire logic                         clk,
  input  wire logic                         rst_n,
  input  wire logic                         in_valid,
  input  wire sdta_pkg::in_word_t           in_word,
  output logic                              in_stall,
  input  wire logic                         cfg_wr_en,
  input  wire logic [sdta_pkg::KEY_W-1:0]   cfg_wr_data,
  input  wire logic                         out_free,
  output sdta_pkg::mem_wr_t                 mem_wr,
  output sdta_pkg::mem_rd_t                 mem_rd,
  output sdta_pkg::emit_t                   emit
);
  import sdta_pkg::*;

  state_t                        state_r, state_nxt;
  logic [KEY_W-1:0]              key_r, key_nxt;
  logic                          second_r, second_nxt;
  logic [KEY_W-1:0]              first_r, first_nxt;
  logic [BLK_CHARS*CHAR_W-1:0]   chars_r, chars_nxt;
  logic [ADDR_W-1:0]             wr_addr_r, wr_addr_nxt;
  logic [2:0]                    wr_cnt_r, wr_cnt_nxt;
  logic [TEXT_LEN-1:0]           mask_r, mask_nxt;
  logic [ADDR_W-1:0]             rd_cnt_r, rd_cnt_nxt;
  logic                          pend_r, pend_nxt;
  logic [ADDR_W-1:0]             pend_idx_r, pend_idx_nxt;

  logic              accept;
  logic [KEY_W-1:0]  word;
  logic [7:0]        hdr;
  logic [ADDR_W-1:0] base;
  logic              issue;
  logic              load;

  assign accept = in_valid && (state_r == ST_IDLE);
  assign word   = {in_word.byte0_in, in_word.byte1_in, in_word.byte2_in} ^ key_r;
  assign hdr    = first_r[23:16];
  assign base   = {1'b0, hdr[1:0], 2'b00} + {3'b000, hdr[1:0]};
  assign issue  = (state_r == ST_EMIT) && (rd_cnt_r != END_CNT) && (!pend_r || out_free);
  assign load   = (state_r == ST_EMIT) && pend_r && out_free;

  always_comb begin
    state_nxt    = state_r;
    key_nxt      = cfg_wr_en ? cfg_wr_data : key_r;
    second_nxt   = second_r;
    first_nxt    = first_r;
    chars_nxt    = chars_r;
    wr_addr_nxt  = wr_addr_r;
    wr_cnt_nxt   = wr_cnt_r;
    mask_nxt     = mask_r;
    rd_cnt_nxt   = rd_cnt_r;
    pend_nxt     = pend_r;
    pend_idx_nxt = pend_idx_r;
    case (state_r)
      ST_IDLE: begin
        if (accept) begin
          if (in_word.clear_all) begin
            mask_nxt   = '0;
            second_nxt = 1'b0;
          end else if (in_word.is_sync) begin
            second_nxt = 1'b0;
          end else if (!second_r) begin
            first_nxt  = word;
            second_nxt = 1'b1;
          end else begin
            second_nxt = 1'b0;
            if ((hdr[7:4] == TEXT_TYPE) && (hdr[3:2] == 2'b00)) begin
              chars_nxt   = {word[6:0], word[14:8], word[22:16],
                             first_r[6:0], first_r[14:8]};
              wr_addr_nxt = base;
              wr_cnt_nxt  = '0;
              mask_nxt    = mask_r | (TEXT_LEN'(5'b11111) << base);
              state_nxt   = ST_WRITE;
            end
          end
        end
      end
      ST_WRITE: begin
        chars_nxt   = chars_r >> CHAR_W;
        wr_addr_nxt = wr_addr_r + 5'd1;
        wr_cnt_nxt  = wr_cnt_r + 3'd1;
        if (wr_cnt_r == LAST_WR) begin
          if (mask_r == FULL_MASK) begin
            mask_nxt   = '0;
            rd_cnt_nxt = '0;
            pend_nxt   = 1'b0;
            state_nxt  = ST_EMIT;
          end else begin
            state_nxt = ST_IDLE;
          end
        end
      end
      ST_EMIT: begin
        if (issue) begin
          pend_nxt     = 1'b1;
          pend_idx_nxt = rd_cnt_r;
          rd_cnt_nxt   = rd_cnt_r + 5'd1;
        end else if (load) begin
          pend_nxt = 1'b0;
        end
        if (load && (pend_idx_r == LAST_IDX)) begin
          state_nxt = ST_IDLE;
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r  <= ST_IDLE;
      key_r    <= KEY_RESET;
      second_r <= 1'b0;
      first_r  <= '0;
      mask_r   <= '0;
      rd_cnt_r <= '0;
      pend_r   <= 1'b0;
      wr_cnt_r <= '0;
    end else begin
      state_r  <= state_nxt;
      key_r    <= key_nxt;
      second_r <= second_nxt;
      first_r  <= first_nxt;
      mask_r   <= mask_nxt;
      rd_cnt_r <= rd_cnt_nxt;
      pend_r   <= pend_nxt;
      wr_cnt_r <= wr_cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    chars_r    <= chars_nxt;
    wr_addr_r  <= wr_addr_nxt;
    pend_idx_r <= pend_idx_nxt;
  end

  assign in_stall    = (state_r != ST_IDLE);
  assign mem_wr.en   = (state_r == ST_WRITE);
  assign mem_wr.addr = wr_addr_r;
  assign mem_wr.data = chars_r[CHAR_W-1:0];
  assign mem_rd.en   = issue;
  assign mem_rd.addr = rd_cnt_r;
  assign emit.load   = load;
  assign emit.index  = pend_idx_r;
  assign emit.last   = (pend_idx_r == LAST_IDX);

endmodule

`default_nettype wire

/* sv/slow_data_text_assembler_unit.sv */
// ----------------------------------------------------------------------------
// slow_data_text_assembler_unit
// Assembles 20-character slow-data text messages from voice-frame bytes.
//
// The input channel takes one word per voice frame: three scrambled bytes
// plus sync and clear flags. The result channel gives one word per character
// of a completed message, with its index and a flag on the last one. The
// scrambler key must be written through cfg_wr_en and cfg_wr_data only
// while idle; this binds the user, as the block does not enforce it. A
// completed text block is accepted and then its five characters are
// written into the store memory, one per cycle through its single write
// port. When that block fills the message, the message is read from the
// store and loaded into the output register, one character per cycle
// while the result channel is not stalled; no frame is taken until the
// last character sits in the output register. A stall on the result
// channel holds the current word and pauses the memory reads; no
// character is lost. Synchronous reset returns the key to its default,
// clears the pairing phase and fill mask and empties the output register.
// ----------------------------------------------------------------------------
`default_nettype none

module slow_data_text_assembler_unit (
  input  wire logic                         clk,
  input  wire logic                         rst_n,
  input  wire logic                         in_valid,
  input  wire sdta_pkg::in_word_t           in_word,
  output logic                              in_stall,
  output logic                              out_valid,
  output sdta_pkg::out_word_t               out_word,
  input  wire logic                         out_stall,
  input  wire logic                         cfg_wr_en,
  input  wire logic [sdta_pkg::KEY_W-1:0]   cfg_wr_data
);
  import sdta_pkg::*;

  mem_wr_t           mem_wr;
  mem_rd_t           mem_rd;
  emit_t             emit;
  logic [CHAR_W-1:0] rd_data;
  logic              out_free;
  logic              out_valid_r;
  out_word_t         out_word_r;

  assign out_free = !out_valid_r || !out_stall;

  sdta_ctrl u_ctrl (
    .clk         (clk),
    .rst_n       (rst_n),
    .in_valid    (in_valid),
    .in_word     (in_word),
    .in_stall    (in_stall),
    .cfg_wr_en   (cfg_wr_en),
    .cfg_wr_data (cfg_wr_data),
    .out_free    (out_free),
    .mem_wr      (mem_wr),
    .mem_rd      (mem_rd),
    .emit        (emit)
  );

  sdta_store u_store (
    .clk     (clk),
    .wr      (mem_wr),
    .rd      (mem_rd),
    .rd_data (rd_data)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (emit.load) begin
      out_valid_r <= 1'b1;
    end else if (!out_stall) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (emit.load) begin
      out_word_r.text_char  <= rd_data;
      out_word_r.char_index <= emit.index;
      out_word_r.last_char  <= emit.last;
    end
  end

  assign out_valid = out_valid_r;
  assign out_word  = out_word_r;

endmodule

`default_nettype wire

/* sv/sdta_checker.sv */
// ----------------------------------------------------------------------------
// sdta_checker
// Port-level checks for the slow-data text assembler, bound to the top level.
// ----------------------------------------------------------------------------
`default_nettype none

module sdta_checker (
  input wire logic                         clk,
  input wire logic                         rst_n,
  input wire logic                         in_stall,
  input wire logic                         out_valid,
  input wire sdta_pkg::out_word_t          out_word,
  input wire logic                         out_stall
);
  import sdta_pkg::*;

  a_reset_idle: assert property (@(posedge clk)
    !rst_n |=> !in_stall && !out_valid)
    else $error("block not idle after reset");

  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_stall |=> out_valid && $stable(out_word))
    else $error("stalled result word changed");

  a_last_index: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_word.last_char |-> out_word.char_index == LAST_IDX)
    else $error("last character flag not at final index");

  a_run_steps: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_stall && !out_word.last_char |=>
      out_valid && (out_word.char_index == $past(out_word.char_index) + 5'd1))
    else $error("character run broken");

endmodule

bind slow_data_text_assembler_unit sdta_checker u_sdta_checker (.*);

`default_nettype wire
